// ===== src/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants for the positional list
// Sizes, operation codes and status codes used by the list and its store.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef logic [1:0]        mode_type;
   typedef logic [1:0]        status_type;
   typedef logic [POS_W-1:0]  position_type;
   typedef logic [4:0]        count_type;
   typedef logic signed [DATA_W-1:0] data_type;

   localparam mode_type MODE_INSERT = 2'd0;
   localparam mode_type MODE_DELETE = 2'd1;
   localparam mode_type MODE_DUMP   = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== src/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete: bounded list with insert/delete by position
// Insert shifts entries back one slot at a time through the registered-read
// entry memory, then drops the new value in; delete shifts entries up the same
// way; dump reads out each entry in turn; an empty dump or a flagged item goes
// straight to the result. One item at a time, and results wait for room at the
// output. Synchronous reset empties the list; the entry memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pli_pkg::mode_type     req_mode,
   input  wire pli_pkg::position_type req_position,
   input  wire pli_pkg::data_type     req_value,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pli_pkg::status_type        rsp_status,
   output pli_pkg::count_type         rsp_count,
   output pli_pkg::data_type          rsp_element,
   output logic                       rsp_element_valid,
   output logic                       rsp_last
);

   import pli_pkg::*;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // wait for an item
   localparam logic [2:0] S_INS  = 3'd1;  // insert: check slot, read entry to move back
   localparam logic [2:0] S_SHW  = 3'd2;  // insert: write moved entry one slot back
   localparam logic [2:0] S_DEL  = 3'd3;  // delete: check slot, read entry to move up
   localparam logic [2:0] S_SHD  = 3'd4;  // delete: write moved entry one slot up
   localparam logic [2:0] S_DRD  = 3'd5;  // dump: read entry
   localparam logic [2:0] S_DLD  = 3'd6;  // dump: hand entry to the output register
   localparam logic [2:0] S_FIN  = 3'd7;  // single result for insert/delete/empty dump/errors

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] tgt_ff, tgt_in;
   data_type         value_ff, value_in;
   status_type       status_ff, status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   count_type        rsp_count_ff, rsp_count_in;
   data_type         rsp_element_ff, rsp_element_in;
   logic             rsp_ev_ff, rsp_ev_in;
   logic             rsp_last_ff, rsp_last_in;

   // memory port
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   data_type         wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   // widened operands for position checks
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic [CMP_W-1:0] idx_x;
   logic             out_free;
   logic             accept;

   // the single index step unit shared by every loop
   logic             step_up;
   logic [CNT_W-1:0] idx_step;

   assign pos_x    = CMP_W'(req_position);
   assign cnt_x    = CMP_W'(count_ff);
   assign idx_x    = CMP_W'(idx_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign idx_step = step_up ? CNT_W'(idx_ff + 1'b1) : CNT_W'(idx_ff - 1'b1);

   assign req_ready = (state_ff == S_IDLE);

   pli_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      tgt_in         = tgt_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_element_in = rsp_element_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IDX_W-1:0];
      wr_data        = data_type'(rd_data);
      rd_en          = 1'b0;
      rd_addr        = idx_ff[IDX_W-1:0];
      step_up        = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in  = req_value;
               tgt_in    = CNT_W'(pos_x - 1'b1);
               status_in = ST_OK;
               unique case (req_mode)
                  MODE_INSERT: begin
                     // full is checked before the position
                     if (cnt_x >= CMP_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_FIN;
                     end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                        status_in = ST_RANGE;
                        state_in  = S_FIN;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS;
                     end
                  end
                  MODE_DELETE: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = ST_RANGE;
                        state_in  = S_FIN;
                     end else begin
                        idx_in   = CNT_W'(pos_x - 1'b1);
                        state_in = S_DEL;
                     end
                  end
                  MODE_DUMP: begin
                     if (count_ff == '0) begin
                        state_in = S_FIN;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DRD;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                     state_in  = S_FIN;
                  end
               endcase
            end
         end

         S_INS: begin
            if (idx_ff == tgt_ff) begin
               // slot is open: drop the new value in
               wr_en    = 1'b1;
               wr_data  = value_ff;
               count_in = CNT_W'(count_ff + 1'b1);
               state_in = S_FIN;
            end else begin
               step_up  = 1'b0;
               rd_en    = 1'b1;
               rd_addr  = idx_step[IDX_W-1:0];
               state_in = S_SHW;
            end
         end

         S_SHW: begin
            wr_en    = 1'b1;
            step_up  = 1'b0;
            idx_in   = idx_step;
            state_in = S_INS;
         end

         S_DEL: begin
            if (idx_x + 1'b1 < cnt_x) begin
               rd_en    = 1'b1;
               rd_addr  = idx_step[IDX_W-1:0];
               state_in = S_SHD;
            end else begin
               count_in = CNT_W'(count_ff - 1'b1);
               state_in = S_FIN;
            end
         end

         S_SHD: begin
            wr_en    = 1'b1;
            idx_in   = idx_step;
            state_in = S_DEL;
         end

         S_DRD: begin
            rd_en    = 1'b1;
            state_in = S_DLD;
         end

         S_DLD: begin
            // read data holds until the next read, so wait here for room
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_count_in   = cnt_x[4:0];
               rsp_element_in = data_type'(rd_data);
               rsp_ev_in      = 1'b1;
               rsp_last_in    = (idx_x + 1'b1 == cnt_x);
               if (idx_x + 1'b1 == cnt_x) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_step;
                  state_in = S_DRD;
               end
            end
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_count_in   = cnt_x[4:0];
               rsp_element_in = '0;
               rsp_ev_in      = 1'b0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and loop registers: no reset needed
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      tgt_ff         <= tgt_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_valid = rsp_ev_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   // list never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_x <= CMP_W'(CAPACITY))
      else $error("entry count above capacity");

   // the count moves only out of the insert or delete loop
   a_count_source: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_INS || $past(state_ff) == S_DEL || $past(reset)))
      else $error("entry count changed outside insert/delete");

   // dump never writes the store
   a_dump_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRD || state_ff == S_DLD) |-> !wr_en)
      else $error("store written during dump");

   // a result without an entry is always the only one of its item
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ev_ff) |-> rsp_last_ff)
      else $error("result without entry not marked last");
`endif

endmodule

`default_nettype wire

// ===== tb/positional_list_insert_delete_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb: self-checking bench for the positional list
// Drives insert, delete and dump items through the request channel and checks
// every response against an in-bench model of the list. The run goes through
// directed corner cases, random list traffic under several idle/stall phases,
// and a long response hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_tb;

   import pli_pkg::*;

   // Mode three has no name in the package; it must be flagged as a bad position.
   localparam mode_type MODE_UNUSED = 2'd3;

   // This settle time covers the slowest insert, delete or dump with margin.
   localparam int SETTLE_CYCLES  = 120;
   localparam int DRAIN_LIMIT    = 50000;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      status_type status;
      count_type  count;
      data_type   element;
      logic       element_valid;
      logic       last;
   } list_result_type;

   // -------------------------------------------------------------------------
   // Clock, reset and DUT ports
   // -------------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_valid    = 1'b0;
   logic         req_ready;
   mode_type     req_mode     = MODE_DUMP;
   position_type req_position = '0;
   data_type     req_value    = '0;

   logic         rsp_valid;
   logic         rsp_ready    = 1'b0;
   status_type   rsp_status;
   count_type    rsp_count;
   data_type     rsp_element;
   logic         rsp_element_valid;
   logic         rsp_last;

   initial forever #2 clock = ~clock;

   positional_list_insert_delete dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_element       (rsp_element),
      .rsp_element_valid (rsp_element_valid),
      .rsp_last          (rsp_last)
   );

   // -------------------------------------------------------------------------
   // List model and the responses it still owes
   // -------------------------------------------------------------------------
   data_type        list_entries[$];
   list_result_type pending_results[$];

   int send_idle_pct   = 0;   // chance per cycle that the sender holds off
   int recv_stall_pct  = 0;   // chance per cycle that the receiver stalls
   int hold_off_req    = 0;   // cycles of forced stall, picked up by the receiver
   int hold_off_left   = 0;

   int sent_items      = 0;
   int checked_results = 0;
   int mismatches      = 0;
   int stray_results   = 0;
   int leftover        = 0;
   int full_outcomes   = 0;
   int range_outcomes  = 0;
   int dumped_entries  = 0;
   int max_depth_seen  = 0;

   // Queue one response, with the count taken after the operation.
   function automatic void owe_result(status_type st, data_type elem, logic ev, logic lst);
      list_result_type r;
      r.status        = st;
      r.count         = count_type'(list_entries.size());
      r.element       = elem;
      r.element_valid = ev;
      r.last          = lst;
      pending_results.push_back(r);
      if (st == ST_FULL) full_outcomes++;
      if (st == ST_RANGE) range_outcomes++;
   endfunction

   // Apply one item to the model and owe the responses it causes.
   function automatic void apply_list_op(mode_type mode, position_type pos, data_type val);
      int n;
      n = list_entries.size();
      case (mode)
         MODE_INSERT: begin
            // A full list wins over a bad position.
            if (n >= CAPACITY) begin
               owe_result(ST_FULL, '0, 1'b0, 1'b1);
            end else if (pos < 1 || pos > n + 1) begin
               owe_result(ST_RANGE, '0, 1'b0, 1'b1);
            end else begin
               list_entries.insert(pos - 1, val);
               owe_result(ST_OK, '0, 1'b0, 1'b1);
            end
         end
         MODE_DELETE: begin
            if (pos < 1 || pos > n) begin
               owe_result(ST_RANGE, '0, 1'b0, 1'b1);
            end else begin
               list_entries.delete(pos - 1);
               owe_result(ST_OK, '0, 1'b0, 1'b1);
            end
         end
         MODE_DUMP: begin
            // An empty list still answers once, with no element.
            if (n == 0) begin
               owe_result(ST_OK, '0, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  owe_result(ST_OK, list_entries[i], 1'b1, (i == n - 1));
               dumped_entries += n;
            end
         end
         default: owe_result(ST_RANGE, '0, 1'b0, 1'b1);
      endcase
      if (list_entries.size() > max_depth_seen) max_depth_seen = list_entries.size();
   endfunction

   // -------------------------------------------------------------------------
   // Sender: offer one item and hold it until accepted. Valid stays high when
   // the next item follows at once, so it is never dropped and raised in one step.
   // -------------------------------------------------------------------------
   task automatic send_item(mode_type mode, position_type pos, data_type val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      apply_list_op(mode, pos, val);
      sent_items++;
      do @(posedge clock); while (!req_ready);
   endtask

   // One random item: mostly legal inserts and deletes that walk the list
   // between empty and full, some dumps, and a slice of raw noise.
   bit filling = 1'b1;

   task automatic send_random_op();
      int r;
      int n;
      n = list_entries.size();
      r = $urandom_range(99);
      if (n >= CAPACITY) filling = 1'b0;
      if (n == 0) filling = 1'b1;
      if (r < 8) begin
         send_item(mode_type'($urandom_range(3)), position_type'($urandom_range(31)),
                   data_type'($urandom));
      end else if (r < 18) begin
         send_item(MODE_DUMP, position_type'($urandom_range(31)), data_type'($urandom));
      end else if ($urandom_range(99) < (filling ? 75 : 25)) begin
         send_item(MODE_INSERT, position_type'($urandom_range(n + 1, 1)), data_type'($urandom));
      end else begin
         send_item(MODE_DELETE, position_type'($urandom_range(n > 0 ? n : 1, 1)),
                   data_type'($urandom));
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stalls, plus a forced hold-off counted down here.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_req > 0) begin
         hold_off_left = hold_off_req;
         hold_off_req  = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Response checker: pop the oldest owed response and compare each field.
   // -------------------------------------------------------------------------
   list_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            if (mismatches + stray_results < 10)
               $display({"ERROR: unexpected response status=%0d count=%0d ",
                         "element=%0d ev=%0b last=%0b"},
                        rsp_status, rsp_count, rsp_element, rsp_element_valid, rsp_last);
            stray_results++;
         end else begin
            want = pending_results.pop_front();
            checked_results++;
            if (rsp_status !== want.status || rsp_count !== want.count ||
                rsp_element !== want.element || rsp_element_valid !== want.element_valid ||
                rsp_last !== want.last) begin
               if (mismatches + stray_results < 10)
                  $display({"ERROR: response %0d: expected status=%0d count=%0d element=%0d ",
                            "ev=%0b last=%0b, got status=%0d count=%0d ",
                            "element=%0d ev=%0b last=%0b"},
                           checked_results, want.status, want.count, want.element,
                           want.element_valid, want.last, rsp_status, rsp_count, rsp_element,
                           rsp_element_valid, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Empty-list errors, extremes of value and position, fill to capacity,
   // full-list inserts, a full dump and deletes at both ends.
   task automatic test_directed_cases();
      int n;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_item(MODE_DELETE, 5'd1, '0);              // delete on empty list
      send_item(MODE_DUMP, 5'd0, '0);                // empty dump
      send_item(MODE_INSERT, 5'd0, 32'sd5);          // position zero
      send_item(MODE_INSERT, 5'd2, 32'sd5);          // past the end of an empty list
      send_item(MODE_UNUSED, 5'd31, '1);             // unused mode
      send_item(MODE_INSERT, 5'd1, 32'sh7FFF_FFFF);
      send_item(MODE_INSERT, 5'd1, 32'sh8000_0000);  // push to front
      send_item(MODE_INSERT, 5'd3, -32'sd1);         // append
      send_item(MODE_INSERT, 5'd2, '0);              // middle
      // Fill the rest, spreading inserts over front, back and middle.
      for (int k = 0; list_entries.size() < CAPACITY; k++) begin
         n = list_entries.size();
         send_item(MODE_INSERT,
                   position_type'((k % 3 == 0) ? 1 : (k % 3 == 1) ? n + 1 : n / 2 + 1),
                   data_type'($urandom));
      end
      send_item(MODE_INSERT, 5'd0, 32'sd1);          // full wins over a bad position
      send_item(MODE_INSERT, 5'd31, 32'sd1);
      send_item(MODE_DUMP, 5'd31, '1);
      send_item(MODE_DELETE, position_type'(CAPACITY), '0);   // delete last
      send_item(MODE_DELETE, 5'd1, '0);                       // delete first
      send_item(MODE_DELETE, position_type'(list_entries.size() + 1), '0);
      send_item(MODE_DELETE, 5'd31, '0);
   endtask

   // Random list traffic under one idle/stall setting.
   task automatic test_random_traffic(int send_pct, int stall_pct, int items);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (items) send_random_op();
   endtask

   // Fill the list, then hold the receiver off for a long stretch while the
   // sender keeps offering a full dump and more items, so the input backs up.
   task automatic test_receiver_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (list_entries.size() < CAPACITY)
         send_item(MODE_INSERT, position_type'($urandom_range(list_entries.size() + 1, 1)),
                   data_type'($urandom));
      hold_off_req = HOLD_OFF_CYCLES;
      send_item(MODE_DUMP, '0, '0);
      send_item(MODE_INSERT, 5'd3, data_type'($urandom));
      send_item(MODE_DELETE, 5'd8, '0);
      send_item(MODE_INSERT, 5'd8, data_type'($urandom));
      send_item(MODE_DUMP, '0, '0);
      send_item(MODE_DELETE, 5'd16, '0);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int drain_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(0, 0, 110);
      test_random_traffic(67, 0, 110);
      test_random_traffic(0, 67, 110);
      test_random_traffic(34, 34, 110);
      test_receiver_hold_off();

      // Drop valid right after the final acceptance so nothing extra goes in.
      req_valid      <= 1'b0;
      recv_stall_pct = 0;
      drain_cycles   = 0;
      while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      leftover = pending_results.size();
      if (leftover != 0)
         $display("ERROR: %0d responses never arrived", leftover);

      $display("Ran %0d items, checked %0d responses, %0d entries dumped, depth up to %0d.",
               sent_items, checked_results, dumped_entries, max_depth_seen);
      $display("Saw %0d list-full and %0d bad-position outcomes; %0d mismatches, %0d stray.",
               full_outcomes, range_outcomes, mismatches, stray_results);
      if (mismatches == 0 && stray_results == 0 && leftover == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("ERROR: run timed out with %0d responses outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
